[design/spqp_pkg.sv]
// Shared types and constants for the sensor payload quotient packer.
// No dependencies; every other design file imports this package.
package spqp_pkg;

    localparam int KEY_W       = 16;   // divisor register width
    localparam int VAL_W       = 26;   // scaled value width
    localparam int REM_W       = 24;   // enough for any value that does not saturate
    localparam int QUO_W       = 8;    // quotient bits
    localparam int POS_W       = 4;    // byte position width
    localparam int RAIN_INPUTS = 4;    // rain fields in one record
    localparam int RAIN_W      = 32;
    localparam int DIV_STEPS   = 2;    // restoring steps per divider stage
    localparam int DIV_STAGES  = QUO_W / DIV_STEPS;

    localparam logic [7:0] PAD_BYTE   = 8'd255;
    localparam logic [7:0] SAT_QUO    = 8'd255;
    localparam logic [6:0] VOLT_SCALE = 7'd100;
    localparam logic [9:0] RAIN_SCALE = 10'd1000;

    typedef enum logic [1:0] {
        KIND_ERR = 2'd0,
        KIND_QUO = 2'd1,
        KIND_REM = 2'd2,
        KIND_PAD = 2'd3
    } kind_t;

    // one payload byte in flight through the divider pipeline
    typedef struct packed {
        logic [POS_W-1:0] pos;
        kind_t            kind;
        logic             last;
        logic             sat;
        logic [7:0]       lit;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } job_t;

endpackage

[design/sensor_payload_quotient_packer_core.sv]
// Top level of the sensor payload quotient packer.
// Uses spqp_pkg, spqp_front, spqp_serializer and spqp_div_stage.

// Each accepted record yields 2*(2+rain pairs)+2 payload bytes (14 with four
// rain values), one per cycle on m_* unless m_tready stalls: the error byte, a
// quotient/remainder pair for voltage*100, distance and each rain value*1000,
// then a pad of 255. A pair is value / split_divisor and its low remainder byte,
// or 255 and 0 when the value exceeds split_divisor*255. The next record is taken
// into the input register while the current one is still being sent. Between a
// record and its first byte lie the input register, scaled record register, byte
// sequencer, four divider stages of two quotient bits each, and the output
// register, the first of these loading at the accepting edge. Write split_divisor
// only while idle.
module sensor_payload_quotient_packer_core import spqp_pkg::*; #(
    parameter int RAIN_VALUES = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,      // split_divisor
    input  logic          s_tvalid,
    output logic          s_tready,
    // [7:0] error_flags, [23:8] battery_voltage, [39:24] distance_reading,
    // [71:40] rain_accumulated, [103:72] rain_event_accumulated,
    // [135:104] rain_total_accumulated, [167:136] rain_per_hour
    input  logic [167:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // [7:0] payload_byte, [11:8] byte_position, [15:12] zero
    output logic [15:0]   m_tdata,
    output logic          m_tlast         // last_byte
);

    localparam int RAIN_PAIRS = (RAIN_VALUES < 1) ? 1 :
                                ((RAIN_VALUES > RAIN_INPUTS) ? RAIN_INPUTS : RAIN_VALUES);
    localparam int NVAL = 2 + RAIN_PAIRS;

    logic [KEY_W-1:0]                  key_reg;
    logic [RAIN_INPUTS-1:0][RAIN_W-1:0] rain_in;

    logic                              fr_valid;
    logic                              fr_ready;
    logic [7:0]                        fr_error;
    logic [NVAL-1:0][VAL_W-1:0]        fr_scaled;

    logic                              chain_valid [DIV_STAGES+1];
    logic                              chain_ready [DIV_STAGES+1];
    job_t                              chain_job   [DIV_STAGES+1];

    logic                              out_v_reg;
    logic [7:0]                        out_byte_reg;
    logic [POS_W-1:0]                  out_pos_reg;
    logic                              out_last_reg;
    logic [7:0]                        byte_next;
    job_t                              fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= KEY_W'(1);
        end else if (cfg_we) begin
            key_reg <= cfg_wdata;
        end
    end

    for (genvar g = 0; g < RAIN_INPUTS; g++) begin : g_unpack
        assign rain_in[g] = s_tdata[40 + g*RAIN_W +: RAIN_W];
    end

    spqp_front #(.NVAL(NVAL)) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .error_flags      (s_tdata[7:0]),
        .battery_voltage  (s_tdata[23:8]),
        .distance_reading (s_tdata[39:24]),
        .rain_in          (rain_in),
        .out_valid        (fr_valid),
        .out_ready        (fr_ready),
        .out_error        (fr_error),
        .out_scaled       (fr_scaled)
    );

    spqp_serializer #(.NVAL(NVAL)) u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key       (key_reg),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_error  (fr_error),
        .in_scaled (fr_scaled),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_job   (chain_job[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        spqp_div_stage #(.HI(QUO_W - 1 - g*DIV_STEPS)) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key       (key_reg),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_job    (chain_job[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_job   (chain_job[g+1])
        );
    end

    assign fin                     = chain_job[DIV_STAGES];
    assign chain_ready[DIV_STAGES] = !out_v_reg || m_tready;

    // zero divisor without saturation means the value was zero
    always_comb begin
        case (fin.kind)
            KIND_QUO: byte_next = fin.sat ? SAT_QUO :
                                  ((key_reg == '0) ? 8'd0 : fin.quo);
            KIND_REM: byte_next = (fin.sat || key_reg == '0) ? 8'd0 : fin.rem[7:0];
            KIND_ERR: byte_next = fin.lit;
            KIND_PAD: byte_next = fin.lit;
            default:  byte_next = fin.lit;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (chain_ready[DIV_STAGES]) begin
            out_v_reg <= chain_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (chain_ready[DIV_STAGES] && chain_valid[DIV_STAGES]) begin
            out_byte_reg <= byte_next;
            out_pos_reg  <= fin.pos;
            out_last_reg <= fin.last;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'd0, out_pos_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

endmodule

[design/spqp_front.sv]
// Input register and fixed-point scaling of one sensor record.
// Depends on spqp_pkg.
module spqp_front import spqp_pkg::*; #(
    parameter int NVAL = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          error_flags,
    input  logic [15:0]                         battery_voltage,
    input  logic [15:0]                         distance_reading,
    input  logic [RAIN_INPUTS-1:0][RAIN_W-1:0]  rain_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_error,
    output logic [NVAL-1:0][VAL_W-1:0]          out_scaled
);

    localparam int RAIN_PAIRS = NVAL - 2;

    logic                                 v_reg;
    logic [7:0]                           err_reg;
    logic [15:0]                          volt_reg;
    logic [15:0]                          dist_reg;
    logic [RAIN_PAIRS-1:0][RAIN_W-1:0]    rain_reg;
    logic [22:0]                          volt_prod;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_error = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            err_reg  <= error_flags;
            volt_reg <= battery_voltage;
            dist_reg <= distance_reading;
            rain_reg <= rain_in[RAIN_PAIRS-1:0];
        end
    end

    // Q8.8 volts times 100, fraction dropped
    assign volt_prod     = 23'(volt_reg) * 23'(VOLT_SCALE);
    assign out_scaled[0] = VAL_W'(volt_prod[22:8]);
    assign out_scaled[1] = VAL_W'(dist_reg);

    // Q16.16 rain times 1000, fraction dropped: one multiplier per lane
    for (genvar g = 0; g < RAIN_PAIRS; g++) begin : g_rain
        logic [41:0] rain_prod;
        assign rain_prod         = 42'(rain_reg[g]) * 42'(RAIN_SCALE);
        assign out_scaled[2 + g] = rain_prod[16 +: VAL_W];
    end

endmodule

[design/spqp_serializer.sv]
// Holds one scaled record and walks it out as one byte job per cycle
// unless out_ready stalls, with the saturation check done on the way out. Depends on spqp_pkg.
module spqp_serializer import spqp_pkg::*; #(
    parameter int NVAL = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [KEY_W-1:0]            key,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  in_error,
    input  logic [NVAL-1:0][VAL_W-1:0]  in_scaled,
    output logic                        out_valid,
    input  logic                        out_ready,
    output job_t                        out_job
);

    localparam int TOTAL = 2 * NVAL + 2;
    localparam int IDX_W = $clog2(NVAL);

    logic                          rec_v_reg;
    logic [7:0]                    err_reg;
    logic [NVAL-1:0][VAL_W-1:0]    val_reg;
    logic [POS_W-1:0]              cnt_reg;
    logic                          job_v_reg;
    job_t                          job_reg;

    logic                          job_ready;
    logic                          emit;
    logic                          at_last;
    logic                          is_pair;
    logic [POS_W-1:0]              cnt_m1;
    logic [IDX_W-1:0]              idx;
    logic [VAL_W-1:0]              cur_val;
    logic [23:0]                   key_x255;
    job_t                          job_next;

    assign job_ready = !job_v_reg || out_ready;
    assign emit      = rec_v_reg && job_ready;
    assign at_last   = (cnt_reg == POS_W'(TOTAL - 1));
    assign is_pair   = (cnt_reg != '0) && !at_last;
    assign in_ready  = !rec_v_reg || (emit && at_last);

    assign cnt_m1   = cnt_reg - POS_W'(1);
    assign idx      = is_pair ? cnt_m1[IDX_W:1] : '0;
    assign cur_val  = val_reg[idx];
    assign key_x255 = {key, 8'd0} - 24'(key);

    always_comb begin
        job_next      = '0;
        job_next.pos  = cnt_reg;
        job_next.last = at_last;
        job_next.sat  = cur_val > VAL_W'(key_x255);
        job_next.rem  = cur_val[REM_W-1:0];
        if (cnt_reg == '0) begin
            job_next.kind = KIND_ERR;
            job_next.lit  = err_reg;
        end else if (at_last) begin
            job_next.kind = KIND_PAD;
            job_next.lit  = PAD_BYTE;
        end else if (cnt_reg[0]) begin
            job_next.kind = KIND_QUO;
        end else begin
            job_next.kind = KIND_REM;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_v_reg <= 1'b0;
            cnt_reg   <= '0;
            job_v_reg <= 1'b0;
        end else begin
            if (in_ready && in_valid) begin
                rec_v_reg <= 1'b1;
            end else if (emit && at_last) begin
                rec_v_reg <= 1'b0;
            end
            if (emit) begin
                cnt_reg <= at_last ? '0 : cnt_reg + POS_W'(1);
            end
            if (job_ready) begin
                job_v_reg <= rec_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            err_reg <= in_error;
            val_reg <= in_scaled;
        end
        if (emit) begin
            job_reg <= job_next;
        end
    end

    assign out_valid = job_v_reg;
    assign out_job   = job_reg;

endmodule

[design/spqp_div_stage.sv]
// One stage of the restoring divider: DIV_STEPS quotient bits per stage,
// starting at bit HI. Depends on spqp_pkg.
module spqp_div_stage import spqp_pkg::*; #(
    parameter int HI = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [KEY_W-1:0]   key,
    input  logic               in_valid,
    output logic               in_ready,
    input  job_t               in_job,
    output logic               out_valid,
    input  logic               out_ready,
    output job_t               out_job
);

    logic             v_reg;
    job_t             job_reg;
    job_t             job_next;
    logic [REM_W-1:0] trial;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        job_next = in_job;
        trial    = '0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            trial = REM_W'(key) << (HI - s);
            if (job_next.rem >= trial) begin
                job_next.rem          = job_next.rem - trial;
                job_next.quo[HI - s]  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            job_reg <= job_next;
        end
    end

    assign out_valid = v_reg;
    assign out_job   = job_reg;

endmodule

[tb/spqp_payload_checker.sv]
// Scoreboard for the sensor payload packer: watches the record, result and divisor ports,
// predicts every payload word and compares each one, field by field, in order.
// Depends on spqp_pkg.
module spqp_payload_checker import spqp_pkg::*; #(
    parameter int RAIN_VALUES = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [167:0]  s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [15:0]   m_tdata,
    input  logic          m_tlast,
    output int            mismatches,
    output int            bytes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAIN_PAIRS  = (RAIN_VALUES < 1) ? 1 :
                                 ((RAIN_VALUES > RAIN_INPUTS) ? RAIN_INPUTS : RAIN_VALUES);
    localparam int VALUE_COUNT = 2 + RAIN_PAIRS;
    localparam int PAYLOAD_LEN = 2 * VALUE_COUNT + 2;

    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             last;
    } payload_word_t;

    payload_word_t    expected_bytes[$];
    logic [KEY_W-1:0] divisor = 16'd1;
    int               mismatch_total = 0;

    // {quotient, remainder byte}; saturates to 255/0 above key*255
    function automatic logic [15:0] split_value(input logic [VAL_W-1:0] value,
                                                input logic [KEY_W-1:0] key);
        logic [31:0] ceiling;
        logic [31:0] quo;
        logic [31:0] rem;
        ceiling = 32'(key) * 32'd255;
        if (32'(value) > ceiling) return {SAT_QUO, 8'd0};
        if (key == '0) return 16'd0;
        quo = 32'(value) / 32'(key);
        rem = 32'(value) % 32'(key);
        return {quo[7:0], rem[7:0]};
    endfunction

    function automatic void predict_payload(input logic [167:0] rec);
        logic [VAL_W-1:0] scaled_vals [VALUE_COUNT];
        logic [7:0]       payload [PAYLOAD_LEN];
        logic [63:0]      product;
        logic [15:0]      pair;
        payload_word_t    word;
        int               j;
        int               k;
        // Q8.8 volts -> hundredths, Q16.16 rain -> thousandths, truncated
        product = (64'(rec[23:8]) * 64'(VOLT_SCALE)) >> 8;
        scaled_vals[0] = product[VAL_W-1:0];
        scaled_vals[1] = VAL_W'(rec[39:24]);
        for (j = 0; j < RAIN_PAIRS; j++) begin
            product = (64'(rec[40 + 32*j +: 32]) * 64'(RAIN_SCALE)) >> 16;
            scaled_vals[2 + j] = product[VAL_W-1:0];
        end
        payload[0] = rec[7:0];
        for (j = 0; j < VALUE_COUNT; j++) begin
            pair = split_value(scaled_vals[j], divisor);
            payload[1 + 2*j] = pair[15:8];
            payload[2 + 2*j] = pair[7:0];
        end
        payload[PAYLOAD_LEN-1] = PAD_BYTE;
        for (k = 0; k < PAYLOAD_LEN; k++) begin
            word.data = payload[k];
            word.pos  = POS_W'(k);
            word.last = (k == PAYLOAD_LEN - 1);
            expected_bytes.push_back(word);
        end
    endfunction

    always @(posedge aclk) begin
        payload_word_t want;
        if (!aresetn) begin
            divisor = 16'd1;
            expected_bytes.delete();
        end else begin
            if (cfg_we) divisor = cfg_wdata;
            if (s_tvalid && s_tready) predict_payload(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    mismatch_total++;
                    $display("%0t ns: unexpected word data=%0d pos=%0d last=%0b, none expected",
                             $time, m_tdata[7:0], m_tdata[11:8], m_tlast);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata[7:0] !== want.data) begin
                        mismatch_total++;
                        $display("%0t ns: payload_byte expected %0d actual %0d (pos %0d)",
                                 $time, want.data, m_tdata[7:0], want.pos);
                    end
                    if (m_tdata[11:8] !== want.pos) begin
                        mismatch_total++;
                        $display("%0t ns: byte_position expected %0d actual %0d",
                                 $time, want.pos, m_tdata[11:8]);
                    end
                    if (m_tlast !== want.last) begin
                        mismatch_total++;
                        $display("%0t ns: last_byte expected %0b actual %0b (pos %0d)",
                                 $time, want.last, m_tlast, want.pos);
                    end
                end
            end
        end
        mismatches <= mismatch_total;
        bytes_owed <= expected_bytes.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the payload packer testbench: clock, reset, divisor writes, record stimulus
// and result-side stalls, verdict. Depends on spqp_pkg, spqp_payload_checker and the core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spqp_pkg::*;

    localparam int RAIN_VALUES = 4;
    localparam int IDLE_LIMIT  = 2000;   // cycles with no word moving on either side

    logic          aclk;
    logic          aresetn;
    logic          cfg_we;
    logic [15:0]   cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [167:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [15:0]   m_tdata;
    logic          m_tlast;

    int mismatches;
    int bytes_owed;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int records_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    sensor_payload_quotient_packer_core #(.RAIN_VALUES(RAIN_VALUES)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    spqp_payload_checker #(.RAIN_VALUES(RAIN_VALUES)) payload_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .bytes_owed (bytes_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result-side backpressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: watchdog, no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [167:0] make_record(input logic [7:0] err, input logic [15:0] volt,
                                                 input logic [15:0] dist_mm,
                                                 input logic [31:0] rain_acc,
                                                 input logic [31:0] rain_evt,
                                                 input logic [31:0] rain_tot,
                                                 input logic [31:0] rain_hr);
        return {rain_hr, rain_tot, rain_evt, rain_acc, dist_mm, volt, err};
    endfunction

    // mostly masked-down values so plenty of pairs stay below saturation
    function automatic logic [31:0] rand_value(input int width);
        logic [31:0] mask;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return mask;
            2, 3:    return $urandom & mask;
            default: return $urandom & (mask >> $urandom_range(width - 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_divisor();
        case ($urandom_range(5))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'd0;
            3:       return 16'($urandom_range(255, 2));
            4:       return 16'($urandom_range(4095, 256));
            default: return 16'($urandom_range(65535, 1));
        endcase
    endfunction

    task automatic send_record(input logic [167:0] rec);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= rec;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        records_sent++;
    endtask

    // hold the sender off until every predicted word has come out
    task automatic drain_payloads();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bytes_owed != 0) @(posedge aclk);
    endtask

    task automatic write_divisor(input logic [15:0] key);
        drain_payloads();
        cfg_wdata <= key;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 16'd0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, bit patterns, zero divisor, saturation edges
        write_divisor(16'd1);
        send_record(make_record(8'h00, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0));
        send_record(make_record(8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_record(make_record(8'h55, 16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                32'h0001_0000, 32'h0000_FFFF));
        send_record(make_record(8'hAA, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                32'hFFFF_0000, 32'h0000_0001));
        write_divisor(16'd0);
        send_record(make_record(8'h01, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0));
        send_record(make_record(8'h80, 16'h0000, 16'h0001, 32'h0, 32'h0000_0041, 32'h0, 32'h0));
        send_record(make_record(8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // key 100: 25500 sits exactly on the ceiling, 25501 just over it
        write_divisor(16'd100);
        send_record(make_record(8'h3C, 16'hFF00, 16'd25500, 32'd1671168, 32'd1671234,
                                32'd65536, 32'd0));
        send_record(make_record(8'hC3, 16'hFFFF, 16'd25501, 32'd1671233, 32'd66, 32'd0,
                                32'hFFFF_FFFF));
        // key 256: largest remainder byte next to the ceiling
        write_divisor(16'd256);
        send_record(make_record(8'h0F, 16'h0A3D, 16'd65280, 32'h0100_0000, 32'h0, 32'h0, 32'h0));
        send_record(make_record(8'hF0, 16'h0100, 16'd65279, 32'h0, 32'h0, 32'h0, 32'h0));
        write_divisor(16'hFFFF);
        send_record(make_record(8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_record(make_record(8'h5A, 16'h8000, 16'hFFFE, 32'h0011_0000, 32'h0010_FFFF,
                                32'h8000_0000, 32'h0000_8000));
        // remainder wider than a byte keeps only its low bits
        write_divisor(16'd1000);
        send_record(make_record(8'h7E, 16'h0A00, 16'd999, 32'h0003_E7FF, 32'h0, 32'h0, 32'h0));

        // random: receiver-heavy stalls, sender-heavy stalls, then none
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 17 : ((phase == 1) ? 85 : 0);
            dst_idle_pct = (phase == 0) ? 85 : ((phase == 1) ? 17 : 0);
            for (int blk = 0; blk < 4; blk++) begin
                write_divisor(pick_divisor());
                repeat (9) begin
                    send_record(make_record(8'(rand_value(8)), 16'(rand_value(16)),
                                            16'(rand_value(16)), rand_value(32),
                                            rand_value(32), rand_value(32), rand_value(32)));
                end
            end
        end

        drain_payloads();
        repeat (30) @(posedge aclk);

        if (bytes_owed != 0)
            $display("%0t ns: %0d expected words never arrived", $time, bytes_owed);
        $display("covered %0d sensor records over %0d divisor settings, 0/1/65535 among them",
                 records_sent, settings_used);
        $display("stall mixes: sender-heavy, receiver-heavy, none; %0d mismatches", mismatches);
        if (mismatches == 0 && bytes_owed == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
design/spqp_pkg.sv
design/spqp_front.sv
design/spqp_serializer.sv
design/spqp_div_stage.sv
design/sensor_payload_quotient_packer_core.sv
tb/spqp_payload_checker.sv
tb/tb_top.sv
